// ===== rtl/pipt_pkg.sv =====
package pipt_pkg;

	localparam int CW   = 16;          // coordinate bits
	localparam int RW   = 3 * CW;      // packed register width
	localparam int VW   = CW + 2;      // corner coordinate
	localparam int DW   = CW + 3;      // corner/point difference
	localparam int XW   = 2 * DW + 1;  // cross product component
	localparam int PW   = DW + XW;     // one dot product term
	localparam int TW   = PW + 2;      // triple product
	localparam int GW   = TW + 2;      // sum of four magnitudes
	localparam int SW   = TW + 4;      // sum of twelve magnitudes
	localparam int NTET = 12;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [VW-1:0] corner_t;
	typedef logic signed [DW-1:0] diff_t;
	typedef logic signed [XW-1:0] cross_t;
	typedef logic [TW-1:0]        mag_t;
	typedef logic [1:0]           cfg_idx_t;
	typedef logic [2:0]           cidx_t;

	localparam cfg_idx_t REG_ORIGIN = 2'd0;
	localparam cfg_idx_t REG_EDGE_A = 2'd1;
	localparam cfg_idx_t REG_EDGE_B = 2'd2;
	localparam cfg_idx_t REG_EDGE_C = 2'd3;

	// face triangles as corner indexes (corner bit0 = +A, bit1 = +B, bit2 = +C)
	localparam cidx_t TET_B [NTET] = '{3'd0, 3'd1, 3'd0, 3'd2, 3'd0, 3'd1,
		3'd1, 3'd3, 3'd2, 3'd3, 3'd4, 3'd5};
	localparam cidx_t TET_C [NTET] = '{3'd1, 3'd2, 3'd2, 3'd4, 3'd1, 3'd4,
		3'd3, 3'd5, 3'd3, 3'd6, 3'd5, 3'd6};
	localparam cidx_t TET_D [NTET] = '{3'd2, 3'd3, 3'd4, 3'd6, 3'd4, 3'd5,
		3'd5, 3'd7, 3'd6, 3'd7, 3'd6, 3'd7};

	// one cross product component a*b - c*d
	function automatic cross_t xterm(input diff_t a, input diff_t b,
		input diff_t c, input diff_t d);
		logic signed [2*DW-1:0] p;
		logic signed [2*DW-1:0] q;
		p = a * b;
		q = c * d;
		return XW'(p) - XW'(q);
	endfunction

endpackage

// ===== rtl/pipt_dot.sv =====
module pipt_dot (
	input  logic                clk,
	input  pipt_pkg::diff_t     u [3],
	input  pipt_pkg::cross_t    c [3],
	output pipt_pkg::mag_t      mag
);
	import pipt_pkg::*;

	logic signed [PW-1:0] prod_s4 [3];
	logic signed [TW-1:0] sum;
	mag_t                 mag_s5;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			prod_s4[k] <= u[k] * c[k];
		end
		mag_s5 <= mag_t'(sum[TW-1] ? -sum : sum);
	end

	assign sum = TW'(prod_s4[0]) + TW'(prod_s4[1]) + TW'(prod_s4[2]);
	assign mag = mag_s5;

endmodule

// ===== rtl/point_in_parallelepiped_test_core.sv =====
// a point transferred on start gives its flag on done once its valid bit
// has passed through every register of the valid chain
// throughput: one point per cycle, busy stays low, results cannot be stalled
// asynchronous active-low reset clears the pipeline valid bits and the
// four configuration registers to zero
module point_in_parallelepiped_test_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  pipt_pkg::coord_t   point_x,
	input  pipt_pkg::coord_t   point_y,
	input  pipt_pkg::coord_t   point_z,
	output logic               done,
	output logic               inside_res,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  pipt_pkg::cfg_idx_t cfg_index,
	input  logic [pipt_pkg::RW-1:0] cfg_data
);
	import pipt_pkg::*;

	// configuration registers
	logic [RW-1:0] origin_q, edge_a_q, edge_b_q, edge_c_q;

	// valid bits, one per stage
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	// item path
	coord_t  p_s1 [3];
	diff_t   da_s2 [NTET][3];
	diff_t   da_s3 [NTET][3];
	mag_t    mag_tet [NTET];
	logic [GW-1:0] grp_s6 [3];
	logic [SW-1:0] tot_s7;
	logic    inside_s8;

	// configuration path, advancing in step with the item path
	coord_t  org_c [3], ea_c [3], eb_c [3], ec_c [3];
	corner_t corner_c [8][3];
	corner_t corner_s1 [8][3];
	coord_t  ea_s1 [3], eb_s1 [3], ec_s1 [3];
	diff_t   db_s2 [NTET][3];
	diff_t   dc_s2 [NTET][3];
	cross_t  cr_s3 [NTET][3];
	diff_t   ea_s2 [3], ea_s3 [3];
	cross_t  dcr_s2 [3], dcr_s3 [3];
	mag_t    mag_det;
	logic [SW-1:0] det6_s6, det6_s7;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// configuration write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= '0;
			edge_a_q <= '0;
			edge_b_q <= '0;
			edge_c_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ORIGIN: origin_q <= cfg_data;
				REG_EDGE_A: edge_a_q <= cfg_data;
				REG_EDGE_B: edge_b_q <= cfg_data;
				REG_EDGE_C: edge_c_q <= cfg_data;
				default:    origin_q <= origin_q;
			endcase
		end
	end

	// unpack components and form the eight corners
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			org_c[k] = coord_t'(origin_q[k*CW +: CW]);
			ea_c[k]  = coord_t'(edge_a_q[k*CW +: CW]);
			eb_c[k]  = coord_t'(edge_b_q[k*CW +: CW]);
			ec_c[k]  = coord_t'(edge_c_q[k*CW +: CW]);
		end
		for (int j = 0; j < 8; j++) begin
			for (int k = 0; k < 3; k++) begin
				corner_c[j][k] = VW'(org_c[k])
					+ (((j % 2) == 1)       ? VW'(ea_c[k]) : '0)
					+ ((((j / 2) % 2) == 1) ? VW'(eb_c[k]) : '0)
					+ (((j / 4) == 1)       ? VW'(ec_c[k]) : '0);
			end
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// payload stages, no reset
	always_ff @(posedge clk) begin
		// stage 1: capture point and corners
		p_s1[0] <= point_x;
		p_s1[1] <= point_y;
		p_s1[2] <= point_z;
		corner_s1 <= corner_c;
		ea_s1 <= ea_c;
		eb_s1 <= eb_c;
		ec_s1 <= ec_c;

		// stage 2: edge differences of each tetrahedron, relative to its last corner, and B x C of the box
		for (int t = 0; t < NTET; t++) begin
			for (int k = 0; k < 3; k++) begin
				da_s2[t][k] <= DW'(p_s1[k]) - DW'(corner_s1[TET_D[t]][k]);
				db_s2[t][k] <= DW'(corner_s1[TET_B[t]][k])
					- DW'(corner_s1[TET_D[t]][k]);
				dc_s2[t][k] <= DW'(corner_s1[TET_C[t]][k])
					- DW'(corner_s1[TET_D[t]][k]);
			end
		end
		for (int k = 0; k < 3; k++) begin
			ea_s2[k] <= DW'(ea_s1[k]);
		end
		dcr_s2[0] <= xterm(DW'(eb_s1[1]), DW'(ec_s1[2]), DW'(eb_s1[2]), DW'(ec_s1[1]));
		dcr_s2[1] <= xterm(DW'(eb_s1[2]), DW'(ec_s1[0]), DW'(eb_s1[0]), DW'(ec_s1[2]));
		dcr_s2[2] <= xterm(DW'(eb_s1[0]), DW'(ec_s1[1]), DW'(eb_s1[1]), DW'(ec_s1[0]));

		// stage 3: cross products of the face edges
		da_s3 <= da_s2;
		for (int t = 0; t < NTET; t++) begin
			cr_s3[t][0] <= xterm(db_s2[t][1], dc_s2[t][2], db_s2[t][2], dc_s2[t][1]);
			cr_s3[t][1] <= xterm(db_s2[t][2], dc_s2[t][0], db_s2[t][0], dc_s2[t][2]);
			cr_s3[t][2] <= xterm(db_s2[t][0], dc_s2[t][1], db_s2[t][1], dc_s2[t][0]);
		end
		ea_s3  <= ea_s2;
		dcr_s3 <= dcr_s2;

		// stages 4 and 5 sit in the dot product lanes

		// stage 6: partial sums of four, and six times the volume
		for (int g = 0; g < 3; g++) begin
			grp_s6[g] <= GW'(mag_tet[4*g]) + GW'(mag_tet[4*g+1])
				+ GW'(mag_tet[4*g+2]) + GW'(mag_tet[4*g+3]);
		end
		det6_s6 <= (SW'(mag_det) << 2) + (SW'(mag_det) << 1);

		// stage 7: total
		tot_s7  <= SW'(grp_s6[0]) + SW'(grp_s6[1]) + SW'(grp_s6[2]);
		det6_s7 <= det6_s6;

		// stage 8: compare
		inside_s8 <= (tot_s7 <= det6_s7);
	end

	// triple product lanes, two stages each
	for (genvar t = 0; t < NTET; t++) begin : g_tet
		pipt_dot u_dot (
			.clk (clk),
			.u   (da_s3[t]),
			.c   (cr_s3[t]),
			.mag (mag_tet[t])
		);
	end

	pipt_dot u_det (
		.clk (clk),
		.u   (ea_s3),
		.c   (dcr_s3),
		.mag (mag_det)
	);

	assign done       = v_s8;
	assign inside_res = inside_s8;

endmodule

// ===== rtl/pipt_chk.sv =====
module pipt_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic inside_res,
	input logic cfg_valid,
	input logic cfg_ready
);

	// each transfer is followed by its result strobe on done
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##8 done)
		else $error("no result strobe eight cycles after a transfer");

	// every flag goes back to an earlier transfer
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 8))
		else $error("result strobe without a transfer eight cycles back");

	// the block never refuses a point
	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// configuration port never refuses
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

	// flag is defined whenever it is strobed
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(inside_res))
		else $error("unknown result");

endmodule

bind point_in_parallelepiped_test_core pipt_chk u_pipt_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.inside_res (inside_res),
	.cfg_valid  (cfg_valid),
	.cfg_ready  (cfg_ready)
);

// ===== verif/tb.sv =====
module tb;
	import pipt_pkg::*;

	// one point to classify
	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	// a configuration write
	typedef struct packed {
		cfg_idx_t      idx;
		logic [RW-1:0] data;
	} cfg_wr_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	coord_t point_x, point_y, point_z;
	logic done;
	logic inside_res;
	logic cfg_valid;
	logic cfg_ready;
	cfg_idx_t cfg_index;
	logic [RW-1:0] cfg_data;

	point_in_parallelepiped_test_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.point_x   (point_x),
		.point_y   (point_y),
		.point_z   (point_z),
		.done      (done),
		.inside_res(inside_res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	localparam int PIPE_LAT  = 8;
	localparam longint LIMIT = 400000;

	// predictor copy of the shape registers
	logic [RW-1:0] shape_reg [4];

	// pending points for the driver; the initial block fills this queue
	point_t point_q[$];
	// flags still owed by the block, oldest first
	logic   flag_q[$];

	// config writes requested by the sequencer, handled by the driver
	cfg_wr_t cfg_q[$];

	int     n_err;
	int     n_flags;
	int     n_inside;
	int     n_points;
	longint cyc;
	bit     hold_send;   // sequencer asks the driver to stop sending
	bit     no_idle;     // last part of the run: no bursts of idle
	int     gap_left;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic got, input logic want);
		$display("mismatch at cycle %0d: %s got %0b want %0b", cyc, what, got, want);
		n_err++;
	endtask

	// signed component i of a packed register, sign-extended wide
	function automatic longint comp(input logic [RW-1:0] r, input int i);
		coord_t c;
		c = r[i*CW +: CW];
		return longint'(c);
	endfunction

	// exact u . (v x w) in 128 bits
	function automatic logic signed [127:0] triple_prod(input longint u[3],
		input longint v[3], input longint w[3]);
		logic signed [127:0] c0, c1, c2;
		c0 = 128'(v[1]) * w[2] - 128'(v[2]) * w[1];
		c1 = 128'(v[2]) * w[0] - 128'(v[0]) * w[2];
		c2 = 128'(v[0]) * w[1] - 128'(v[1]) * w[0];
		return c0 * u[0] + c1 * u[1] + c2 * u[2];
	endfunction

	function automatic logic signed [127:0] mag(input logic signed [127:0] a);
		return (a < 0) ? -a : a;
	endfunction

	// inside test: sum of twelve tetrahedron triple products (six times their volumes) against 6 |det|
	function automatic logic predict_inside(input point_t p);
		longint corner [9][3];
		longint ea[3], eb[3], ec[3], da[3], db[3], dc[3];
		logic signed [127:0] vol_sum, box6;
		int tv [12][4];
		tv = '{'{0,1,2,3}, '{0,2,3,4}, '{0,1,3,5}, '{0,3,5,7},
			'{0,1,2,5}, '{0,2,5,6}, '{0,2,4,6}, '{0,4,6,8},
			'{0,3,4,7}, '{0,4,7,8}, '{0,5,6,7}, '{0,6,7,8}};
		for (int k = 0; k < 3; k++) begin
			ea[k] = comp(shape_reg[REG_EDGE_A], k);
			eb[k] = comp(shape_reg[REG_EDGE_B], k);
			ec[k] = comp(shape_reg[REG_EDGE_C], k);
		end
		corner[0][0] = longint'(p.x);
		corner[0][1] = longint'(p.y);
		corner[0][2] = longint'(p.z);
		// corner n (1..8): bit0 of n-1 adds A, bit1 adds B, bit2 adds C
		for (int n = 1; n < 9; n++)
			for (int k = 0; k < 3; k++)
				corner[n][k] = comp(shape_reg[REG_ORIGIN], k)
					+ (((n-1) & 1) ? ea[k] : 0)
					+ (((n-1) & 2) ? eb[k] : 0)
					+ (((n-1) & 4) ? ec[k] : 0);
		vol_sum = 0;
		for (int t = 0; t < 12; t++) begin
			for (int k = 0; k < 3; k++) begin
				da[k] = corner[tv[t][0]][k] - corner[tv[t][3]][k];
				db[k] = corner[tv[t][1]][k] - corner[tv[t][3]][k];
				dc[k] = corner[tv[t][2]][k] - corner[tv[t][3]][k];
			end
			vol_sum += mag(triple_prod(da, db, dc));
		end
		box6 = 6 * mag(triple_prod(ea, eb, ec));
		return vol_sum <= box6;
	endfunction

	function automatic logic [RW-1:0] pack3(input int x, input int y, input int z);
		return {CW'(z), CW'(y), CW'(x)};
	endfunction

	function automatic coord_t rnd_coord();
		case ($urandom_range(0, 5))
			0: return coord_t'($urandom_range(0, 1) ? 16'h7fff : 16'h8000);
			1: return coord_t'($urandom);
			default: return coord_t'(int'($urandom_range(0, 400)) - 200);
		endcase
	endfunction

	// driver: config writes go out first, points go in on start once the config queue is empty
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start     <= 1'b0;
			point_x   <= '0;
			point_y   <= '0;
			point_z   <= '0;
			cfg_valid <= 1'b0;
			cfg_index <= REG_ORIGIN;
			cfg_data  <= '0;
			gap_left  <= 0;
		end else begin
			logic   sent;
			point_t p;
			sent = start && !busy;
			if (sent) begin
				flag_q.push_back(predict_inside({point_x, point_y, point_z}));
				n_points++;
			end
			if (cfg_valid && cfg_ready) begin
				shape_reg[cfg_index] = cfg_data;
				void'(cfg_q.pop_front());
			end
			// config channel
			if (cfg_q.size() > 0) begin
				cfg_valid <= 1'b1;
				cfg_index <= cfg_q[0].idx;
				cfg_data  <= cfg_q[0].data;
			end else begin
				cfg_valid <= 1'b0;
			end
			// point channel
			if (start && !sent) begin
				// keep the current point up until it transfers
			end else if (gap_left > 0) begin
				start    <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (!no_idle && $urandom_range(0, 9) == 0) begin
				start    <= 1'b0;
				gap_left <= $urandom_range(0, 11);
			end else if (!hold_send && cfg_q.size() == 0 && point_q.size() > 0) begin
				p = point_q.pop_front();
				start   <= 1'b1;
				point_x <= p.x;
				point_y <= p.y;
				point_z <= p.z;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: every done pulse checks against the oldest expectation
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (arst_n && done) begin
			if (flag_q.size() == 0) begin
				report_mismatch("unexpected done", done, 1'b0);
			end else begin
				logic want;
				want = flag_q.pop_front();
				if (inside_res !== want)
					report_mismatch("inside_res", inside_res, want);
				n_flags++;
				if (want) n_inside++;
			end
		end
		if (cyc > LIMIT) begin
			$display("timeout after %0d cycles", cyc);
			$display("simulation failed");
			$finish;
		end
	end

	// halfway through the queue stop sending until every owed flag is back,
	// then let the rest go and wait until the block is quiet
	task automatic drain();
		int keep;
		keep = point_q.size() / 2;
		if (keep > 0) begin
			while (point_q.size() > keep)
				@(posedge clk);
			hold_send = 1'b1;
			while (start || flag_q.size() > 0)
				@(posedge clk);
			hold_send = 1'b0;
		end
		while (point_q.size() > 0 || cfg_q.size() > 0)
			@(posedge clk);
		wait_quiet();
	endtask

	task automatic wait_quiet();
		while (point_q.size() > 0 || start || flag_q.size() > 0)
			@(posedge clk);
		repeat (PIPE_LAT + 2) @(posedge clk);
	endtask

	task automatic set_shape(input logic [RW-1:0] o, input logic [RW-1:0] a,
		input logic [RW-1:0] b, input logic [RW-1:0] c);
		cfg_q.push_back({REG_ORIGIN, o});
		cfg_q.push_back({REG_EDGE_A, a});
		cfg_q.push_back({REG_EDGE_B, b});
		cfg_q.push_back({REG_EDGE_C, c});
		while (cfg_q.size() > 0) @(posedge clk);
		@(posedge clk);
	endtask

	// random points, mostly near the box so both flags show up
	task automatic push_points(input int n);
		point_t p;
		longint px, py, pz;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) != 0) begin
				px = comp(shape_reg[REG_ORIGIN], 0);
				py = comp(shape_reg[REG_ORIGIN], 1);
				pz = comp(shape_reg[REG_ORIGIN], 2);
				// fractions of each edge in eighths, slightly beyond [0,1]
				for (int e = 1; e < 4; e++) begin
					int f;
					f = $urandom_range(0, 10) - 1;
					px += comp(shape_reg[e], 0) * f / 8;
					py += comp(shape_reg[e], 1) * f / 8;
					pz += comp(shape_reg[e], 2) * f / 8;
				end
				p.x = coord_t'(px + $urandom_range(0, 2) - 1);
				p.y = coord_t'(py + $urandom_range(0, 2) - 1);
				p.z = coord_t'(pz + $urandom_range(0, 2) - 1);
			end else begin
				p = {rnd_coord(), rnd_coord(), rnd_coord()};
			end
			point_q.push_back(p);
		end
	endtask

	initial begin
		n_err = 0; n_flags = 0; n_inside = 0; n_points = 0; cyc = 0;
		hold_send = 1'b0; no_idle = 1'b0;
		for (int i = 0; i < 4; i++) shape_reg[i] = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero box after reset: every point counts as inside, since all volumes are zero
		point_q.push_back({16'sd0, 16'sd0, 16'sd0});
		point_q.push_back({16'sd1, 16'sd0, 16'sd0});
		point_q.push_back({16'sh7fff, 16'sh7fff, 16'sh7fff});
		wait_quiet();

		// unit-ish cube with corner, interior, face and outside points
		set_shape(pack3(0, 0, 0), pack3(10, 0, 0), pack3(0, 10, 0), pack3(0, 0, 10));
		point_q.push_back({16'sd0, 16'sd0, 16'sd0});
		point_q.push_back({16'sd10, 16'sd10, 16'sd10});
		point_q.push_back({16'sd5, 16'sd5, 16'sd5});
		point_q.push_back({16'sd5, 16'sd0, 16'sd5});
		point_q.push_back({16'sd11, 16'sd5, 16'sd5});
		point_q.push_back({-16'sd1, 16'sd5, 16'sd5});
		point_q.push_back({16'sh8000, 16'sh8000, 16'sh8000});
		point_q.push_back({16'sh7fff, 16'sh8000, 16'sh7fff});
		drain();

		// extreme box from the most negative coordinate up to -1 on each axis
		set_shape({16'h8000, 16'h8000, 16'h8000}, {16'h0, 16'h0, 16'h7fff},
			{16'h0, 16'h7fff, 16'h0}, {16'h7fff, 16'h0, 16'h0});
		point_q.push_back({16'sh8000, 16'sh8000, 16'sh8000});
		point_q.push_back({16'sh7fff, 16'sh7fff, 16'sh7fff});
		point_q.push_back({16'sd0, 16'sd0, 16'sd0});
		point_q.push_back({-16'sd1, -16'sd1, -16'sd1});
		drain();

		// flat box: zero volume, point on the plane and off it
		set_shape(pack3(0, 0, 0), pack3(5, 0, 0), pack3(0, 5, 0), pack3(5, 5, 0));
		point_q.push_back({16'sd0, 16'sd0, 16'sd0});
		point_q.push_back({16'sd2, 16'sd2, 16'sd0});
		point_q.push_back({16'sd2, 16'sd2, 16'sd1});
		drain();

		// random shapes, sheared boxes in all signs plus a few wide ones
		for (int ph = 0; ph < 14; ph++) begin
			logic [RW-1:0] r[4];
			for (int i = 0; i < 4; i++) begin
				if (ph % 5 == 4)
					r[i] = RW'({$urandom, $urandom});
				else
					r[i] = pack3($urandom_range(0, 400) - 200,
						$urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200);
			end
			set_shape(r[0], r[1], r[2], r[3]);
			if (ph == 13) no_idle = 1'b1;
			push_points(80);
			drain();
		end

		$display("covered %0d points over 18 box shapes, %0d flags checked, %0d inside",
			n_points, n_flags, n_inside);
		if (n_err == 0 && flag_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d errors, %0d flags never came", n_err, flag_q.size());
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/pipt_pkg.sv
rtl/pipt_dot.sv
rtl/point_in_parallelepiped_test_core.sv
rtl/pipt_chk.sv
verif/tb.sv
